### sv/assert_macros.svh
// Assertion macros shared by the detector row decode modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRD_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/drd_pkg.sv
`default_nettype none

package drd_pkg;

   localparam int unsigned ELEM_W      = 32;
   localparam int unsigned CLASS_W     = 7;
   localparam int unsigned CONF_W      = 17;
   localparam int unsigned POS_OUT_W   = 13;
   localparam int unsigned SIZE_OUT_W  = 14;
   localparam int unsigned THR_W       = 17;
   localparam int unsigned SCALE_W     = 24;
   localparam int unsigned FRAME_W     = 14;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned POSITION_W  = 8;
   localparam int unsigned BOX_FIELDS  = 4;
   localparam int unsigned BOX_IDX_W   = 2;

   // Fixed point bookkeeping for the box and score arithmetic.
   localparam int unsigned SCORE_SHIFT = 16;
   localparam int unsigned BOX_SHIFT   = 32;
   localparam int unsigned HALF_SHIFT  = 33;
   localparam int unsigned PROD_W      = ELEM_W + SCALE_W + 1;
   localparam int unsigned NUM_W       = PROD_W + 1;
   localparam int unsigned MAG_W       = ELEM_W - 1;
   localparam int unsigned COMB_W      = 2 * MAG_W - SCORE_SHIFT;
   localparam int unsigned COORD_W     = 27;

   localparam int unsigned MAX_CLASSES = 128;
   localparam int unsigned CLASS_CAP_N = (MAX_CLASSES < 128) ? MAX_CLASSES : 128;

   localparam logic [POSITION_W-1:0] CLASS_CAP       = POSITION_W'(CLASS_CAP_N);
   localparam logic [POSITION_W-1:0] OBJ_POS         = POSITION_W'(BOX_FIELDS);
   localparam logic [POSITION_W-1:0] FIRST_CLASS_POS = POSITION_W'(BOX_FIELDS + 1);
   localparam logic [POSITION_W-1:0] POSITION_MAX    = '1;
   localparam logic [POSITION_W-1:0] NO_CLASS        = '1;

   localparam logic [FRAME_W-1:0] FRAME_LIMIT = FRAME_W'(8192);
   localparam logic [CONF_W-1:0]  CONF_MAX    = CONF_W'(65536);

   localparam logic [CSR_INDEX_W-1:0] CSR_SCORE_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_SCALE         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_SCALE         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLASS_COUNT     = 3'd5;

   localparam logic [THR_W-1:0]   THRESHOLD_RESET = THR_W'(16384);
   localparam logic [SCALE_W-1:0] SCALE_RESET     = SCALE_W'(65536);
   localparam logic [FRAME_W-1:0] FRAME_RESET     = FRAME_W'(640);
   localparam logic [COUNT_W-1:0] COUNT_RESET     = COUNT_W'(80);

   typedef logic signed [ELEM_W-1:0] element_type;

   typedef struct packed {
      logic [THR_W-1:0]   score_threshold;
      logic [SCALE_W-1:0] x_scale;
      logic [SCALE_W-1:0] y_scale;
      logic [FRAME_W-1:0] frame_width;
      logic [FRAME_W-1:0] frame_height;
      logic [COUNT_W-1:0] class_count;
   } cfg_type;

   // A finished row that passed the objectness and class gates.
   typedef struct packed {
      element_type        cx;
      element_type        cy;
      element_type        bw;
      element_type        bh;
      logic [MAG_W-1:0]   objectness;
      logic [MAG_W-1:0]   best_score;
      logic [CLASS_W-1:0] class_index;
   } row_rec_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] cx;
      logic signed [PROD_W-1:0] cy;
      logic signed [PROD_W-1:0] bw;
      logic signed [PROD_W-1:0] bh;
      logic [COMB_W-1:0]        combined;
      logic [CLASS_W-1:0]       class_index;
   } prod_rec_type;

endpackage

`default_nettype wire

### sv/drd_req_if.sv
`default_nettype none

interface drd_req_if;
   logic                 valid;
   logic                 ready;
   drd_pkg::element_type element_value;
   logic                 row_end;

   modport source (output valid, output element_value, output row_end, input ready);
   modport sink (input valid, input element_value, input row_end, output ready);
endinterface

`default_nettype wire

### sv/drd_rsp_if.sv
`default_nettype none

interface drd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [drd_pkg::CLASS_W-1:0]        class_index;
   logic [drd_pkg::CONF_W-1:0]         confidence;
   logic [drd_pkg::POS_OUT_W-1:0]      box_left;
   logic [drd_pkg::POS_OUT_W-1:0]      box_top;
   logic [drd_pkg::SIZE_OUT_W-1:0]     box_width;
   logic [drd_pkg::SIZE_OUT_W-1:0]     box_height;

   modport source (output valid, output class_index, output confidence, output box_left,
                   output box_top, output box_width, output box_height, input ready);
   modport sink (input valid, input class_index, input confidence, input box_left,
                 input box_top, input box_width, input box_height, output ready);
endinterface

`default_nettype wire

### sv/drd_row_accum.sv
`default_nettype none
`include "assert_macros.svh"

module drd_row_accum (
   input  wire logic                  clock,
   input  wire logic                  reset,
   drd_req_if.sink                    req_chan,
   input  wire drd_pkg::cfg_type      cfg,
   output logic                       rec_valid,
   output drd_pkg::row_rec_type       rec,
   input  wire logic                  rec_ready
);

   localparam int unsigned ELEM_W     = drd_pkg::ELEM_W;
   localparam int unsigned MAG_W      = drd_pkg::MAG_W;
   localparam int unsigned CLASS_W    = drd_pkg::CLASS_W;
   localparam int unsigned POSITION_W = drd_pkg::POSITION_W;
   localparam int unsigned BOX_IDX_W  = drd_pkg::BOX_IDX_W;

   drd_pkg::element_type     box_ff [drd_pkg::BOX_FIELDS];
   drd_pkg::element_type     objectness_ff;
   drd_pkg::element_type     best_score_ff, best_score_in;
   logic [POSITION_W-1:0]    position_ff, position_in;
   logic [POSITION_W-1:0]    best_class_ff, best_class_in;
   logic                     rejected_ff, rejected_in;
   logic                     rec_valid_ff, rec_valid_in;
   drd_pkg::row_rec_type     rec_ff, rec_in;
   drd_pkg::element_type     value;
   logic                     fire, last, in_class, better, objectness_low, row_kept;
   logic [POSITION_W-1:0]    class_limit, class_slot;

   assign req_chan.ready = !rec_valid_ff || rec_ready;
   assign rec_valid      = rec_valid_ff;
   assign rec            = rec_ff;

   always_comb begin
      value       = req_chan.element_value;
      last        = req_chan.row_end;
      fire        = req_chan.valid && req_chan.ready;
      class_limit = (cfg.class_count > drd_pkg::CLASS_CAP) ? drd_pkg::CLASS_CAP
                                                           : cfg.class_count;
      class_slot  = position_ff - drd_pkg::FIRST_CLASS_POS;
      in_class    = (position_ff >= drd_pkg::FIRST_CLASS_POS) && (class_slot < class_limit);
      better      = in_class && (value > best_score_ff);
      objectness_low = (position_ff == drd_pkg::OBJ_POS) &&
                       (value[ELEM_W-1] ||
                        (value[ELEM_W-2:0] < MAG_W'(cfg.score_threshold)));
      best_score_in = better ? value : best_score_ff;
      best_class_in = better ? class_slot : best_class_ff;
      rejected_in   = rejected_ff || objectness_low;
      position_in   = (position_ff == drd_pkg::POSITION_MAX) ? position_ff
                                                             : position_ff + POSITION_W'(1);
      row_kept      = (position_ff >= drd_pkg::OBJ_POS) && !rejected_in &&
                      (best_class_in != drd_pkg::NO_CLASS);
      rec_valid_in  = fire && last && row_kept;

      rec_in.cx          = box_ff[0];
      rec_in.cy          = box_ff[1];
      rec_in.bw          = box_ff[2];
      rec_in.bh          = box_ff[3];
      rec_in.objectness  = objectness_ff[MAG_W-1:0];
      rec_in.best_score  = best_score_in[MAG_W-1:0];
      rec_in.class_index = best_class_in[CLASS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         best_score_ff <= '0;
         best_class_ff <= drd_pkg::NO_CLASS;
         rejected_ff   <= 1'b0;
         rec_valid_ff  <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            rec_valid_ff <= rec_valid_in;
         end
         if (fire) begin
            if (last) begin
               position_ff   <= '0;
               best_score_ff <= '0;
               best_class_ff <= drd_pkg::NO_CLASS;
               rejected_ff   <= 1'b0;
            end else begin
               position_ff   <= position_in;
               best_score_ff <= best_score_in;
               best_class_ff <= best_class_in;
               rejected_ff   <= rejected_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && (position_ff < drd_pkg::OBJ_POS)) begin
         box_ff[position_ff[BOX_IDX_W-1:0]] <= value;
      end
      if (fire && (position_ff == drd_pkg::OBJ_POS)) begin
         objectness_ff <= value;
      end
      if (rec_valid_in) begin
         rec_ff <= rec_in;
      end
   end

   `DRD_ASSERT_HOLDS(a_best_score_pairs_class, clock, reset,
      best_class_ff != drd_pkg::NO_CLASS, best_score_ff > 0,
      "A best class is held without a positive best score.")
   `DRD_ASSERT_NEXT(a_position_saturates, clock, reset,
      fire && !last && (position_ff == drd_pkg::POSITION_MAX),
      position_ff == drd_pkg::POSITION_MAX,
      "The element position wrapped inside a long row.")

endmodule

`default_nettype wire

### sv/drd_score_product.sv
`default_nettype none
`include "assert_macros.svh"

module drd_score_product (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire drd_pkg::cfg_type      cfg,
   input  wire logic                  in_valid,
   input  wire drd_pkg::row_rec_type  in_rec,
   output logic                       in_ready,
   output logic                       out_valid,
   output drd_pkg::prod_rec_type      out_rec,
   input  wire logic                  out_ready
);

   localparam int unsigned PROD_W      = drd_pkg::PROD_W;
   localparam int unsigned SCALE_W     = drd_pkg::SCALE_W;
   localparam int unsigned MAG_W       = drd_pkg::MAG_W;
   localparam int unsigned SCORE_SHIFT = drd_pkg::SCORE_SHIFT;

   logic                       valid_ff;
   drd_pkg::prod_rec_type      rec_ff, rec_in;
   logic signed [SCALE_W:0]    x_mult, y_mult;
   logic signed [PROD_W-1:0]   cx_prod, cy_prod, bw_prod, bh_prod;
   logic [2*MAG_W-1:0]         score_prod;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_rec   = rec_ff;

   always_comb begin
      x_mult     = $signed({1'b0, cfg.x_scale});
      y_mult     = $signed({1'b0, cfg.y_scale});
      cx_prod    = $signed(in_rec.cx) * x_mult;
      cy_prod    = $signed(in_rec.cy) * y_mult;
      bw_prod    = $signed(in_rec.bw) * x_mult;
      bh_prod    = $signed(in_rec.bh) * y_mult;
      score_prod = in_rec.objectness * in_rec.best_score;

      rec_in.cx          = cx_prod;
      rec_in.cy          = cy_prod;
      rec_in.bw          = bw_prod;
      rec_in.bh          = bh_prod;
      rec_in.combined    = score_prod[2*MAG_W-1:SCORE_SHIFT];
      rec_in.class_index = in_rec.class_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rec_ff <= rec_in;
      end
   end

   `DRD_ASSERT_NEXT(a_product_loaded, clock, reset,
      in_valid && in_ready, valid_ff,
      "A row record was taken but no product was registered.")

endmodule

`default_nettype wire

### sv/drd_box_finish.sv
`default_nettype none
`include "assert_macros.svh"

module drd_box_finish (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire drd_pkg::cfg_type       cfg,
   input  wire logic                   in_valid,
   input  wire drd_pkg::prod_rec_type  in_rec,
   output logic                        in_ready,
   drd_rsp_if.source                   rsp_chan
);

   localparam int unsigned PROD_W     = drd_pkg::PROD_W;
   localparam int unsigned NUM_W      = drd_pkg::NUM_W;
   localparam int unsigned COORD_W    = drd_pkg::COORD_W;
   localparam int unsigned COMB_W     = drd_pkg::COMB_W;
   localparam int unsigned CONF_W     = drd_pkg::CONF_W;
   localparam int unsigned CLASS_W    = drd_pkg::CLASS_W;
   localparam int unsigned FRAME_W    = drd_pkg::FRAME_W;
   localparam int unsigned POS_OUT_W  = drd_pkg::POS_OUT_W;
   localparam int unsigned SIZE_OUT_W = drd_pkg::SIZE_OUT_W;
   localparam int unsigned HALF_SHIFT = drd_pkg::HALF_SHIFT;
   localparam int unsigned BOX_SHIFT  = drd_pkg::BOX_SHIFT;
   localparam logic signed [COORD_W-1:0] ONE_PIXEL = COORD_W'(1);

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] width;
      logic signed [COORD_W-1:0] height;
      logic [CONF_W-1:0]         confidence;
      logic [CLASS_W-1:0]        class_index;
   } box_type;

   typedef struct packed {
      logic                  ok;
      logic [POS_OUT_W-1:0]  pos;
      logic [SIZE_OUT_W-1:0] size;
   } axis_type;

   typedef struct packed {
      logic [CLASS_W-1:0]    class_index;
      logic [CONF_W-1:0]     confidence;
      logic [POS_OUT_W-1:0]  box_left;
      logic [POS_OUT_W-1:0]  box_top;
      logic [SIZE_OUT_W-1:0] box_width;
      logic [SIZE_OUT_W-1:0] box_height;
   } result_type;

   // Corner position: (2 * centre - size) / 2^33, truncated toward zero.
   function automatic logic signed [COORD_W-1:0] half_trunc(
      input logic signed [NUM_W-1:0] num
   );
      logic signed [COORD_W-1:0] floor_val;
      logic                      round_up;
      floor_val = COORD_W'($signed(num[NUM_W-1:HALF_SHIFT]));
      round_up  = num[NUM_W-1] && (|num[HALF_SHIFT-1:0]);
      return floor_val + $signed(COORD_W'(round_up));
   endfunction

   // Box size: product / 2^32, truncated toward zero.
   function automatic logic signed [COORD_W-1:0] size_trunc(
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [COORD_W-1:0] floor_val;
      logic                      round_up;
      floor_val = COORD_W'($signed(prod[PROD_W-1:BOX_SHIFT]));
      round_up  = prod[PROD_W-1] && (|prod[BOX_SHIFT-1:0]);
      return floor_val + $signed(COORD_W'(round_up));
   endfunction

   // A box that starts left of the frame loses the part outside, and one that runs past
   // the far edge is cut there.
   function automatic axis_type clamp_axis(
      input logic signed [COORD_W-1:0] pos,
      input logic signed [COORD_W-1:0] size,
      input logic [FRAME_W-1:0]        frame
   );
      logic signed [COORD_W-1:0] limit, start, span, span_fit;
      axis_type                  res;
      limit    = $signed(COORD_W'((frame > drd_pkg::FRAME_LIMIT) ? drd_pkg::FRAME_LIMIT
                                                                  : frame));
      start    = pos[COORD_W-1] ? '0 : pos;
      span     = pos[COORD_W-1] ? size + pos : size;
      span_fit = ((start + span) > limit) ? limit - start : span;
      res.ok   = span_fit > 0;
      res.pos  = start[POS_OUT_W-1:0];
      res.size = span_fit[SIZE_OUT_W-1:0];
      return res;
   endfunction

   logic                       box_valid_ff, box_valid_in;
   box_type                    box_ff, box_in;
   logic                       out_valid_ff, out_valid_in;
   result_type                 out_ff, out_in;
   logic                       box_ready, out_ready;
   logic signed [NUM_W-1:0]    num_x, num_y;
   logic signed [COORD_W-1:0]  width_t, height_t;
   logic                       score_ok;
   axis_type                   axis_x, axis_y;

   assign out_ready = !out_valid_ff || rsp_chan.ready;
   assign box_ready = !box_valid_ff || out_ready;
   assign in_ready  = box_ready;

   always_comb begin
      num_x    = (NUM_W'($signed(in_rec.cx)) <<< 1) - NUM_W'($signed(in_rec.bw));
      num_y    = (NUM_W'($signed(in_rec.cy)) <<< 1) - NUM_W'($signed(in_rec.bh));
      width_t  = size_trunc($signed(in_rec.bw));
      height_t = size_trunc($signed(in_rec.bh));
      score_ok = in_rec.combined >= COMB_W'(cfg.score_threshold);

      box_in.left        = half_trunc(num_x);
      box_in.top         = half_trunc(num_y);
      box_in.width       = (width_t > 0) ? width_t : ONE_PIXEL;
      box_in.height      = (height_t > 0) ? height_t : ONE_PIXEL;
      box_in.confidence  = (in_rec.combined > COMB_W'(drd_pkg::CONF_MAX)) ? drd_pkg::CONF_MAX
                                                                        : in_rec.combined[CONF_W-1:0];
      box_in.class_index = in_rec.class_index;
      box_valid_in       = in_valid && score_ok;
   end

   always_comb begin
      axis_x = clamp_axis(box_ff.left, box_ff.width, cfg.frame_width);
      axis_y = clamp_axis(box_ff.top, box_ff.height, cfg.frame_height);

      out_in.class_index = box_ff.class_index;
      out_in.confidence  = box_ff.confidence;
      out_in.box_left    = axis_x.pos;
      out_in.box_top     = axis_y.pos;
      out_in.box_width   = axis_x.size;
      out_in.box_height  = axis_y.size;
      out_valid_in       = box_valid_ff && axis_x.ok && axis_y.ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (box_ready) begin
            box_valid_ff <= box_valid_in;
         end
         if (out_ready) begin
            out_valid_ff <= out_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (box_ready && box_valid_in) begin
         box_ff <= box_in;
      end
      if (out_ready && out_valid_in) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.class_index = out_ff.class_index;
   assign rsp_chan.confidence  = out_ff.confidence;
   assign rsp_chan.box_left    = out_ff.box_left;
   assign rsp_chan.box_top     = out_ff.box_top;
   assign rsp_chan.box_width   = out_ff.box_width;
   assign rsp_chan.box_height  = out_ff.box_height;

   `DRD_ASSERT_HOLDS(a_box_inside_frame, clock, reset,
      out_valid_ff,
      (out_ff.box_width != '0) && (out_ff.box_height != '0) &&
      ((15'(out_ff.box_left) + 15'(out_ff.box_width)) <= 15'(drd_pkg::FRAME_LIMIT)) &&
      ((15'(out_ff.box_top) + 15'(out_ff.box_height)) <= 15'(drd_pkg::FRAME_LIMIT)),
      "A reported box is empty or leaves the largest frame.")
   `DRD_ASSERT_HOLDS(a_confidence_saturated, clock, reset,
      out_valid_ff, out_ff.confidence <= drd_pkg::CONF_MAX,
      "The reported confidence exceeds one.")

endmodule

`default_nettype wire

### sv/detector_row_decode_unit.sv
`default_nettype none
// Channel    Direction  Payload
// req_chan   in         element_value, row_end
// rsp_chan   out        class_index, confidence, box_left, box_top, box_width, box_height
// csr_*      in         write enable, register index, write data
//
// One row element is accepted every cycle while rsp_chan keeps up.
// A kept row reaches rsp_chan through these registered stages, in order:
// row record, then the five products, then rounding and score gate, then clamp.
// The product stage holds the deepest logic, a 32 by 25 bit multiply per box field.
// Reset is synchronous, clears row state and all stage valids, and loads register defaults.
// A stalled rsp_chan fills the stages one by one; req_chan stalls only when the row
// record cannot move on.

module detector_row_decode_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   drd_req_if.sink                                 req_chan,
   drd_rsp_if.source                               rsp_chan,
   input  wire logic                               csr_write_enable,
   input  wire logic [drd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [drd_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int unsigned THR_W   = drd_pkg::THR_W;
   localparam int unsigned SCALE_W = drd_pkg::SCALE_W;
   localparam int unsigned FRAME_W = drd_pkg::FRAME_W;
   localparam int unsigned COUNT_W = drd_pkg::COUNT_W;

   drd_pkg::cfg_type       cfg_ff;
   logic                   rec_valid, rec_ready;
   drd_pkg::row_rec_type   rec;
   logic                   prod_valid, prod_ready;
   drd_pkg::prod_rec_type  prod_rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.score_threshold <= drd_pkg::THRESHOLD_RESET;
         cfg_ff.x_scale         <= drd_pkg::SCALE_RESET;
         cfg_ff.y_scale         <= drd_pkg::SCALE_RESET;
         cfg_ff.frame_width     <= drd_pkg::FRAME_RESET;
         cfg_ff.frame_height    <= drd_pkg::FRAME_RESET;
         cfg_ff.class_count     <= drd_pkg::COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            drd_pkg::CSR_SCORE_THRESHOLD: begin
               cfg_ff.score_threshold <= csr_write_data[THR_W-1:0];
            end
            drd_pkg::CSR_X_SCALE: begin
               cfg_ff.x_scale <= csr_write_data[SCALE_W-1:0];
            end
            drd_pkg::CSR_Y_SCALE: begin
               cfg_ff.y_scale <= csr_write_data[SCALE_W-1:0];
            end
            drd_pkg::CSR_FRAME_WIDTH: begin
               cfg_ff.frame_width <= csr_write_data[FRAME_W-1:0];
            end
            drd_pkg::CSR_FRAME_HEIGHT: begin
               cfg_ff.frame_height <= csr_write_data[FRAME_W-1:0];
            end
            drd_pkg::CSR_CLASS_COUNT: begin
               cfg_ff.class_count <= csr_write_data[COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   drd_row_accum u_row_accum (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cfg       (cfg_ff),
      .rec_valid (rec_valid),
      .rec       (rec),
      .rec_ready (rec_ready)
   );

   drd_score_product u_score_product (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (rec_valid),
      .in_rec    (rec),
      .in_ready  (rec_ready),
      .out_valid (prod_valid),
      .out_rec   (prod_rec),
      .out_ready (prod_ready)
   );

   drd_box_finish u_box_finish (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (prod_valid),
      .in_rec   (prod_rec),
      .in_ready (prod_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

### verif/tb_detector_row_decode_unit.sv
`default_nettype none

module tb_detector_row_decode_unit;
   import drd_pkg::*;

   localparam int unsigned STALL_LIMIT  = 3000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned IDLE_PERCENT = 23;
   localparam int unsigned HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [CLASS_W-1:0]    class_index;
      logic [CONF_W-1:0]     confidence;
      logic [POS_OUT_W-1:0]  box_left;
      logic [POS_OUT_W-1:0]  box_top;
      logic [SIZE_OUT_W-1:0] box_width;
      logic [SIZE_OUT_W-1:0] box_height;
   } detection_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   drd_req_if req_bus();
   drd_rsp_if rsp_bus();

   detector_row_decode_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   cfg_type                active_cfg;
   logic [POSITION_W-1:0]  row_slot;
   element_type            box_fields [BOX_FIELDS];
   element_type            row_objectness;
   element_type            top_score;
   logic [POSITION_W-1:0]  top_class;
   bit                     row_dropped;
   detection_type          pending_detections [$];

   int unsigned error_count     = 0;
   int unsigned items_sent      = 0;
   int unsigned stall_cycles    = 0;
   int unsigned rsp_hold_cycles = 0;
   bit          steady_flow     = 1'b0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic void start_row();
      row_slot    = '0;
      top_score   = '0;
      top_class   = NO_CLASS;
      row_dropped = 1'b0;
   endfunction

   // Trims one axis of the box to the frame; false when nothing of the box is left.
   function automatic bit fit_to_frame(inout longint start, inout longint extent,
                                       input longint frame);
      longint span_limit;
      span_limit = (frame > longint'(FRAME_LIMIT)) ? longint'(FRAME_LIMIT) : frame;
      if (start < 0) begin
         extent += start;
         start = 0;
      end
      if (start + extent > span_limit) begin
         extent = span_limit - start;
      end
      return extent > 0;
   endfunction

   function automatic void decode_element(element_type value, bit last);
      int unsigned   slot;
      int unsigned   class_limit;
      longint        cx_prod, cy_prod, w_prod, h_prod;
      longint        left, top, width, height, combined;
      detection_type found;
      slot = row_slot;
      class_limit = (active_cfg.class_count > CLASS_CAP_N) ? CLASS_CAP_N
                                                            : active_cfg.class_count;
      if (slot < OBJ_POS) begin
         box_fields[slot] = value;
      end else if (slot == OBJ_POS) begin
         row_objectness = value;
         if (longint'(value) < longint'(active_cfg.score_threshold)) begin
            row_dropped = 1'b1;
         end
      end else if (slot - FIRST_CLASS_POS < class_limit) begin
         if (value > top_score) begin
            top_score = value;
            top_class = POSITION_W'(slot - FIRST_CLASS_POS);
         end
      end
      if (row_slot != POSITION_MAX) begin
         row_slot++;
      end
      if (!last) begin
         return;
      end
      if (slot < OBJ_POS || row_dropped || top_class == NO_CLASS) begin
         start_row();
         return;
      end
      combined = (longint'(row_objectness) * longint'(top_score)) >>> SCORE_SHIFT;
      if (combined < longint'(active_cfg.score_threshold)) begin
         start_row();
         return;
      end
      cx_prod = longint'(box_fields[0]) * longint'(active_cfg.x_scale);
      cy_prod = longint'(box_fields[1]) * longint'(active_cfg.y_scale);
      w_prod  = longint'(box_fields[2]) * longint'(active_cfg.x_scale);
      h_prod  = longint'(box_fields[3]) * longint'(active_cfg.y_scale);
      // Signed division truncates toward zero, as the box corner requires.
      left   = (2 * cx_prod - w_prod) / 64'sh2_0000_0000;
      top    = (2 * cy_prod - h_prod) / 64'sh2_0000_0000;
      width  = w_prod / 64'sh1_0000_0000;
      height = h_prod / 64'sh1_0000_0000;
      if (width < 1) begin
         width = 1;
      end
      if (height < 1) begin
         height = 1;
      end
      if (!fit_to_frame(left, width, longint'(active_cfg.frame_width)) ||
          !fit_to_frame(top, height, longint'(active_cfg.frame_height))) begin
         start_row();
         return;
      end
      found.class_index = top_class[CLASS_W-1:0];
      found.confidence  = (combined > longint'(CONF_MAX)) ? CONF_MAX : CONF_W'(combined);
      found.box_left    = POS_OUT_W'(left);
      found.box_top     = POS_OUT_W'(top);
      found.box_width   = SIZE_OUT_W'(width);
      found.box_height  = SIZE_OUT_W'(height);
      pending_detections.insert(pending_detections.size(), found);
      start_row();
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      detection_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_detections.size() == 0) begin
            $error("detection of class %0d arrived with none pending", rsp_bus.class_index);
            error_count++;
         end else begin
            want = pending_detections.pop_front();
            check_field("class_index", want.class_index, rsp_bus.class_index);
            check_field("confidence", want.confidence, rsp_bus.confidence);
            check_field("box_left", want.box_left, rsp_bus.box_left);
            check_field("box_top", want.box_top, rsp_bus.box_top);
            check_field("box_width", want.box_width, rsp_bus.box_width);
            check_field("box_height", want.box_height, rsp_bus.box_height);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_element(element_type value, bit last);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.element_value <= value;
      req_bus.row_end       <= last;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      decode_element(value, last);
      items_sent++;
   endtask

   task automatic send_values(element_type values [$]);
      foreach (values[i]) begin
         send_element(values[i], i == values.size() - 1);
      end
   endtask

   task automatic drain_detections();
      req_bus.valid <= 1'b0;
      while (pending_detections.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic program_settings(cfg_type settings);
      write_register(CSR_SCORE_THRESHOLD, CSR_DATA_W'(settings.score_threshold));
      write_register(CSR_X_SCALE, CSR_DATA_W'(settings.x_scale));
      write_register(CSR_Y_SCALE, CSR_DATA_W'(settings.y_scale));
      write_register(CSR_FRAME_WIDTH, CSR_DATA_W'(settings.frame_width));
      write_register(CSR_FRAME_HEIGHT, CSR_DATA_W'(settings.frame_height));
      write_register(CSR_CLASS_COUNT, CSR_DATA_W'(settings.class_count));
      csr_write_enable <= 1'b0;
      active_cfg = settings;
   endtask

   function automatic element_type random_field(int unsigned slot, bit noise);
      int unsigned pick;
      pick = $urandom_range(15);
      if (noise || pick == 0) begin
         return element_type'($urandom);
      end else if (slot < 2) begin
         if (pick < 3) begin
            return -element_type'($urandom_range(40 * 65536));
         end
         return element_type'($urandom_range(900 * 65536));
      end else if (slot < OBJ_POS) begin
         if (pick < 3) begin
            return element_type'($urandom_range(65535));
         end else if (pick == 3) begin
            return -element_type'($urandom_range(1, 50 * 65536));
         end
         return element_type'($urandom_range(400 * 65536));
      end else if (slot == OBJ_POS) begin
         if (pick < 2) begin
            return element_type'(active_cfg.score_threshold);
         end else if (pick == 2) begin
            return -element_type'($urandom_range(1, 65536));
         end
         return element_type'($urandom_range(3 * 65536));
      end
      if (pick < 3) begin
         return -element_type'($urandom_range(65536));
      end
      return element_type'($urandom_range(2 * 65536));
   endfunction

   task automatic send_row(int unsigned length, bit noise);
      for (int unsigned i = 0; i < length; i++) begin
         send_element(random_field(i, noise), i == length - 1);
      end
   endtask

   // Mostly well-formed rows, plus noise, short rows and rows running past the class count.
   task automatic send_random_row();
      int unsigned roll;
      int unsigned class_limit;
      roll = $urandom_range(99);
      class_limit = (active_cfg.class_count > CLASS_CAP_N) ? CLASS_CAP_N
                                                            : active_cfg.class_count;
      if (roll < 8) begin
         send_row($urandom_range(1, 10), 1'b1);
      end else if (roll < 14) begin
         send_row($urandom_range(1, OBJ_POS), 1'b0);
      end else if (roll < 22 && class_limit <= 20) begin
         send_row(FIRST_CLASS_POS + class_limit + $urandom_range(1, 4), 1'b0);
      end else begin
         send_row(FIRST_CLASS_POS + $urandom_range(10), 1'b0);
      end
   endtask

   task automatic test_directed_rows();
      element_type row_values [$];
      row_values = '{32'sh8000_0000, 32'sh7FFF_FFFF};
      send_values(row_values);
      row_values = '{320 * 65536, 240 * 65536, 100 * 65536, 50 * 65536,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
      send_values(row_values);
      row_values = '{-5 * 65536, 630 * 65536, 20 * 65536, 30 * 65536,
                     65536, -1, 0, 65536};
      send_values(row_values);
      row_values = '{0, 0, 32'sh0000_8000, 0, 131072, 32'sh8000_0000, 8192};
      send_values(row_values);
      row_values = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     16383, 32'sh7FFF_FFFF};
      send_values(row_values);
      row_values = '{100 * 65536, 100 * 65536, 10 * 65536, 10 * 65536,
                     16384, 0, 32'sh8000_0000};
      send_values(row_values);
   endtask

   // The row runs past 255 elements; late elements must neither count as scores
   // nor overwrite the box.
   task automatic test_long_row();
      cfg_type     settings;
      int unsigned length;
      element_type value;
      settings = '{THRESHOLD_RESET, SCALE_RESET, SCALE_RESET, FRAME_RESET, FRAME_RESET,
                   COUNT_W'(CLASS_CAP_N)};
      drain_detections();
      program_settings(settings);
      length = $urandom_range(258, 270);
      for (int unsigned i = 0; i < length; i++) begin
         if (i < 2) begin
            value = element_type'($urandom_range(100, 500) << 16);
         end else if (i < OBJ_POS) begin
            value = element_type'($urandom_range(10, 60) << 16);
         end else if (i == OBJ_POS) begin
            value = element_type'(65536);
         end else if (i < FIRST_CLASS_POS + CLASS_CAP_N) begin
            value = random_field(i, 1'b0);
         end else begin
            value = element_type'(32'h7FFF_FFFF);
         end
         send_element(value, i == length - 1);
      end
   endtask

   task automatic test_result_backpressure();
      drain_detections();
      steady_flow = 1'b1;
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (30) begin
         send_element(element_type'($urandom_range(50, 590) << 16), 1'b0);
         send_element(element_type'($urandom_range(50, 590) << 16), 1'b0);
         send_element(element_type'($urandom_range(1, 80) << 16), 1'b0);
         send_element(element_type'($urandom_range(1, 80) << 16), 1'b0);
         send_element(element_type'(65536), 1'b0);
         send_element(element_type'($urandom_range(32768, 65536)), 1'b1);
      end
      drain_detections();
      steady_flow = 1'b0;
   endtask

   task automatic test_random_settings();
      cfg_type     plan [8];
      int unsigned phase_end;
      plan[0] = '{16384, 65536, 65536, 640, 640, 6};
      plan[1] = '{0, 0, 24'hFF_FFFF, 1, 8192, 1};
      plan[2] = '{65536, 24'hFF_FFFF, 0, 8192, 1, 128};
      plan[3] = '{32768, 98304, 49152, 1920, 1080, 3};
      for (int p = 4; p < 6; p++) begin
         plan[p] = '{THR_W'($urandom_range(65536)),
                     SCALE_W'($urandom_range(16384, 262144)),
                     SCALE_W'($urandom_range(16384, 262144)),
                     FRAME_W'($urandom_range(1, 8192)),
                     FRAME_W'($urandom_range(1, 8192)),
                     COUNT_W'($urandom_range(128))};
      end
      plan[6] = '{16384, 65536, 65536, 640, 640, 0};
      plan[7] = '{THRESHOLD_RESET, SCALE_RESET, SCALE_RESET, FRAME_RESET, FRAME_RESET,
                  COUNT_RESET};
      foreach (plan[p]) begin
         drain_detections();
         program_settings(plan[p]);
         steady_flow = (p == 3);
         phase_end = items_sent + ((plan[p].class_count == 0) ? 20 : 90);
         while (items_sent < phase_end) begin
            send_random_row();
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_index             = '0;
      csr_write_data        = '0;
      req_bus.valid         = 1'b0;
      req_bus.element_value = '0;
      req_bus.row_end       = 1'b0;
      rsp_bus.ready         = 1'b0;
      active_cfg = '{THRESHOLD_RESET, SCALE_RESET, SCALE_RESET, FRAME_RESET, FRAME_RESET,
                     COUNT_RESET};
      foreach (box_fields[i]) begin
         box_fields[i] = '0;
      end
      row_objectness = '0;
      start_row();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_rows();
      test_long_row();
      test_result_backpressure();
      test_random_settings();
      drain_detections();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

### detector_row_decode_unit.f
+incdir+sv
sv/drd_pkg.sv
sv/drd_req_if.sv
sv/drd_rsp_if.sv
sv/drd_row_accum.sv
sv/drd_score_product.sv
sv/drd_box_finish.sv
sv/detector_row_decode_unit.sv
verif/tb_detector_row_decode_unit.sv
